// ===== sv/buddy_block_allocator_top_defines.svh =====
// assertion macros for the buddy allocator
// expects aclk and aresetn in the including module
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// types, constants and helper functions of the buddy allocator
// no dependencies
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MAX_CLASS_BITS = 20;
    localparam int MIN_CLASS_BITS = 6;
    localparam int HEADER_BYTES   = 8;
    localparam int NCLASS         = MAX_CLASS_BITS + 1;
    localparam int BLK_BITS       = MAX_CLASS_BITS - MIN_CLASS_BITS;
    localparam int NBLK           = 1 << BLK_BITS;
    localparam int LINK_W         = BLK_BITS + 1;
    localparam int CLS_W          = 5;
    localparam int CNT_W          = 15;
    localparam int OFF_W          = 20;
    localparam int SIZE_W         = 21;
    localparam int WIDE_W         = 22;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NBLK);

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_RESIZE = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_MEM  = 2'd1;
    localparam logic [1:0] STAT_TOO_BIG = 2'd2;

    localparam logic CFG_SEGMENT_BYTES = 1'b0;
    localparam logic CFG_FIRST_OFFSET  = 1'b1;

    localparam logic [SIZE_W-1:0] SEGMENT_RESET = SIZE_W'(1048576);
    localparam logic [OFF_W-1:0]  FIRST_RESET   = OFF_W'(16384);

    typedef struct packed {
        logic [2:0]        op;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFF_W-1:0]  chunk_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  result_offset;
        logic [SIZE_W-1:0] copy_bytes;
        logic [SIZE_W-1:0] usable_bytes;
        logic [SIZE_W-1:0] usage_bytes;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_BLK_RD, ST_FREE_CHK, ST_RS_CHK, ST_Q_CHK,
        ST_NEED, ST_NEED_END,
        ST_G_SRCH, ST_G_SPLIT, ST_G_SPL2, ST_G_SPL3, ST_G_FIN, ST_GR_REL,
        ST_R_CHK, ST_R_TST, ST_R_UP, ST_R_ADD,
        ST_SH, ST_SH_NX, ST_SH_FIN,
        ST_I_CLR, ST_I_LOOP, ST_I_TZ, ST_I_FIT, ST_I_NX,
        ST_RM_RD, ST_RM_WR, ST_AD_1, ST_AD_2,
        ST_DONE
    } state_t;

    function automatic logic [WIDE_W-1:0] pow2(input logic [CLS_W-1:0] c);
        return WIDE_W'(1) << c;
    endfunction

    function automatic logic [SIZE_W-1:0] usable_of(input logic [CLS_W-1:0] c);
        logic [WIDE_W-1:0] p;
        p = pow2(c);
        return (p > WIDE_W'(HEADER_BYTES)) ? SIZE_W'(p - WIDE_W'(HEADER_BYTES)) : '0;
    endfunction

    function automatic logic [CLS_W-1:0] clamp_class(input logic [CLS_W-1:0] c);
        if (c < CLS_W'(MIN_CLASS_BITS)) return CLS_W'(MIN_CLASS_BITS);
        if (c > CLS_W'(MAX_CLASS_BITS)) return CLS_W'(MAX_CLASS_BITS);
        return c;
    endfunction

endpackage

// ===== sv/buddy_block_allocator_top.sv =====
// buddy allocator top level: sequencer, block table memories, free list heads
// depends on bba_pkg and buddy_block_allocator_top_defines.svh
`timescale 1ns / 1ps
`include "buddy_block_allocator_top_defines.svh"

// Binary buddy allocator over a byte region of up to 1 MiB in 64-byte blocks.
// One item is taken at a time; s_ready is low from acceptance until the result
// item is written to the output register. All work runs through one sequencer
// that touches the block table (class, free flag, next and prev links, each a
// 16k-entry memory with one write and one registered read) once per step.
// Steps: an unknown op goes straight to the result; query reads the header;
// free or resize of a free chunk reads the header and returns the offset; free
// reads the header, then merges one buddy per pass; alloc finds the size class
// (one bit a step), searches for the smallest non-empty class at or above it
// (a request with no fitting chunk ends after the search), then splits down to
// it; growing resize reads the header, runs the alloc path and then the free
// path for the old chunk; shrinking resize finds the size class, hands back one
// tail piece per class and rewrites the header; init clears the lists and
// carves chunks, finding each one's alignment one bit a step and halving it to
// fit. A result held by m_ready adds the wait. The table has no clearing pass
// after reset: init writes the header of every chunk it carves, and ops that
// name a chunk must use written headers, which the block itself does not enforce.
module buddy_block_allocator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bba_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bba_pkg::out_item_t            m_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bba_pkg::SIZE_W-1:0]    cfg_wdata
);
    import bba_pkg::*;

    // block table memories
    logic [CLS_W-1:0]  class_mem [NBLK];
    logic              free_mem  [NBLK];
    logic [LINK_W-1:0] next_mem  [NBLK];
    logic [LINK_W-1:0] prev_mem  [NBLK];

    logic                rd_en;
    logic [BLK_BITS-1:0] rd_addr;
    logic [CLS_W-1:0]    rdq_class_reg;
    logic                rdq_free_reg;
    logic [LINK_W-1:0]   rdq_next_reg;
    logic [LINK_W-1:0]   rdq_prev_reg;

    logic                cls_we, fr_we, nx_we, pv_we;
    logic [BLK_BITS-1:0] cls_wa, fr_wa, nx_wa, pv_wa;
    logic [CLS_W-1:0]    cls_wd;
    logic                fr_wd;
    logic [LINK_W-1:0]   nx_wd, pv_wd;

    // sequencer state and work registers
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [2:0]          op_reg, op_next;
    logic [WIDE_W-1:0]   need_v_reg, need_v_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [WIDE_W-1:0]   woff_reg, woff_next;
    logic [CLS_W-1:0]    c_reg, c_next;
    logic [CLS_W-1:0]    nc_reg, nc_next;
    logic [CLS_W-1:0]    oc_reg, oc_next;
    logic [BLK_BITS-1:0] sub_b_reg, sub_b_next;
    logic [CLS_W-1:0]    sub_c_reg, sub_c_next;
    logic [LINK_W-1:0]   hsave_reg, hsave_next;
    logic [BLK_BITS-1:0] bud_b_reg, bud_b_next;
    logic [OFF_W-1:0]    noff_reg, noff_next;
    logic [WIDE_W-1:0]   lo_reg, lo_next;
    logic [WIDE_W-1:0]   hi_reg, hi_next;
    logic [1:0]          st_reg, st_next;
    logic [OFF_W-1:0]    ro_reg, ro_next;
    logic [SIZE_W-1:0]   cp_reg, cp_next;
    logic [SIZE_W-1:0]   us_reg, us_next;
    logic [SIZE_W-1:0]   usage_reg, usage_next;
    logic [LINK_W-1:0]   head_reg [NCLASS];
    logic [LINK_W-1:0]   head_next [NCLASS];
    logic [CNT_W-1:0]    fcnt_reg [NCLASS];
    logic [CNT_W-1:0]    fcnt_next [NCLASS];
    logic [CNT_W-1:0]    acnt_reg [NCLASS];
    logic [CNT_W-1:0]    acnt_next [NCLASS];
    logic [SIZE_W-1:0]   seg_reg, seg_next;
    logic [OFF_W-1:0]    first_reg, first_next;
    logic                mval_reg, mval_next;
    out_item_t           mdata_reg, mdata_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mval_reg;
    assign m_data  = mdata_reg;

    // memories: one write port and one registered read port each
    always_ff @(posedge aclk) begin
        if (cls_we) class_mem[cls_wa] <= cls_wd;
        if (rd_en) rdq_class_reg <= class_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (fr_we) free_mem[fr_wa] <= fr_wd;
        if (rd_en) rdq_free_reg <= free_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (rd_en) rdq_next_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        if (rd_en) rdq_prev_reg <= prev_mem[rd_addr];
    end

    always_comb begin
        logic [WIDE_W-1:0] f;
        logic [WIDE_W-1:0] bud;
        logic [LINK_W-1:0] h;
        logic [CLS_W-1:0]  rc;

        state_next  = state_reg;
        ret_next    = ret_reg;
        op_next     = op_reg;
        need_v_next = need_v_reg;
        off_next    = off_reg;
        woff_next   = woff_reg;
        c_next      = c_reg;
        nc_next     = nc_reg;
        oc_next     = oc_reg;
        sub_b_next  = sub_b_reg;
        sub_c_next  = sub_c_reg;
        hsave_next  = hsave_reg;
        bud_b_next  = bud_b_reg;
        noff_next   = noff_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        st_next     = st_reg;
        ro_next     = ro_reg;
        cp_next     = cp_reg;
        us_next     = us_reg;
        usage_next  = usage_reg;
        head_next   = head_reg;
        fcnt_next   = fcnt_reg;
        acnt_next   = acnt_reg;
        seg_next    = seg_reg;
        first_next  = first_reg;
        mval_next   = mval_reg & ~m_ready;
        mdata_next  = mdata_reg;

        rd_en   = 1'b0;
        rd_addr = off_reg[OFF_W-1:MIN_CLASS_BITS];
        cls_we = 1'b0; cls_wa = sub_b_reg; cls_wd = sub_c_reg;
        fr_we  = 1'b0; fr_wa  = sub_b_reg; fr_wd  = 1'b1;
        nx_we  = 1'b0; nx_wa  = sub_b_reg; nx_wd  = NIL;
        pv_we  = 1'b0; pv_wa  = sub_b_reg; pv_wd  = NIL;

        f   = '0;
        bud = '0;
        h   = head_reg[0];
        rc  = clamp_class(rdq_class_reg);

        // register writes: the user issues them only while no item is in flight; the block does not enforce it
        if (cfg_we) begin
            case (cfg_index)
                CFG_SEGMENT_BYTES: seg_next = cfg_wdata;
                CFG_FIRST_OFFSET:  first_next = cfg_wdata[OFF_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_data.op;
                    need_v_next = WIDE_W'(s_data.size_bytes) + WIDE_W'(HEADER_BYTES - 1);
                    off_next    = s_data.chunk_offset
                                  & ~OFF_W'((1 << MIN_CLASS_BITS) - 1);
                    // carve base: at least one block, block aligned
                    f = (WIDE_W'(first_reg) < pow2(CLS_W'(MIN_CLASS_BITS)))
                        ? pow2(CLS_W'(MIN_CLASS_BITS)) : WIDE_W'(first_reg);
                    lo_next = (f + WIDE_W'((1 << MIN_CLASS_BITS) - 1))
                              & ~WIDE_W'((1 << MIN_CLASS_BITS) - 1);
                    hi_next = (WIDE_W'(seg_reg) > pow2(CLS_W'(MAX_CLASS_BITS)))
                              ? pow2(CLS_W'(MAX_CLASS_BITS)) : WIDE_W'(seg_reg);
                    st_next = STAT_OK;
                    ro_next = '0;
                    cp_next = '0;
                    us_next = '0;
                    c_next  = CLS_W'(MIN_CLASS_BITS);
                    case (s_data.op)
                        OP_INIT:   state_next = ST_I_CLR;
                        OP_ALLOC:  state_next = ST_NEED;
                        OP_FREE:   state_next = ST_BLK_RD;
                        OP_RESIZE: state_next = ST_BLK_RD;
                        OP_QUERY:  state_next = ST_BLK_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end

            ST_BLK_RD: begin
                rd_en   = 1'b1;
                rd_addr = off_reg[OFF_W-1:MIN_CLASS_BITS];
                case (op_reg)
                    OP_FREE:   state_next = ST_FREE_CHK;
                    OP_RESIZE: state_next = ST_RS_CHK;
                    default:   state_next = ST_Q_CHK;
                endcase
            end

            ST_Q_CHK: begin
                ro_next = off_reg;
                if (!rdq_free_reg) us_next = usable_of(rc);
                state_next = ST_DONE;
            end

            ST_FREE_CHK: begin
                if (rdq_free_reg) begin
                    ro_next    = off_reg;
                    state_next = ST_DONE;
                end else begin
                    oc_next        = rc;
                    acnt_next[rc]  = acnt_reg[rc] - CNT_W'(1);
                    usage_next     = usage_reg - SIZE_W'(pow2(rc));
                    woff_next      = WIDE_W'(off_reg);
                    c_next         = rc;
                    state_next     = ST_R_CHK;
                end
            end

            ST_RS_CHK: begin
                if (rdq_free_reg) begin
                    ro_next    = off_reg;
                    state_next = ST_DONE;
                end else begin
                    oc_next    = rc;
                    c_next     = CLS_W'(MIN_CLASS_BITS);
                    state_next = ST_NEED;
                end
            end

            // size class: bit length of size + header - 1, at least 6, one bit a step
            ST_NEED: begin
                if ((need_v_reg >> c_reg) != '0) begin
                    c_next = c_reg + CLS_W'(1);
                end else begin
                    nc_next    = c_reg;
                    state_next = ST_NEED_END;
                end
            end

            ST_NEED_END: begin
                c_next = nc_reg;
                if (nc_reg > CLS_W'(MAX_CLASS_BITS)) begin
                    st_next    = STAT_TOO_BIG;
                    state_next = ST_DONE;
                end else if (op_reg == OP_ALLOC) begin
                    state_next = ST_G_SRCH;
                end else if (nc_reg == oc_reg) begin
                    ro_next    = off_reg;
                    us_next    = usable_of(oc_reg);
                    state_next = ST_DONE;
                end else if (nc_reg > oc_reg) begin
                    state_next = ST_G_SRCH;
                end else begin
                    state_next = ST_SH;
                end
            end

            // find the smallest non-empty class at or above the target
            ST_G_SRCH: begin
                if (c_reg > CLS_W'(MAX_CLASS_BITS)) begin
                    st_next    = STAT_NO_MEM;
                    state_next = ST_DONE;
                end else if (head_reg[c_reg] >= NIL) begin
                    c_next = c_reg + CLS_W'(1);
                end else begin
                    state_next = ST_G_SPLIT;
                end
            end

            ST_G_SPLIT: begin
                state_next = ST_RM_RD;
                if (c_reg > nc_reg) begin
                    sub_b_next = head_reg[c_reg][BLK_BITS-1:0];
                    sub_c_next = c_reg;
                    ret_next   = ST_G_SPL2;
                end else begin
                    sub_b_next = head_reg[nc_reg][BLK_BITS-1:0];
                    sub_c_next = nc_reg;
                    ret_next   = ST_G_FIN;
                end
            end

            // lower half of the split chunk
            ST_G_SPL2: begin
                c_next     = c_reg - CLS_W'(1);
                sub_c_next = c_reg - CLS_W'(1);
                ret_next   = ST_G_SPL3;
                state_next = ST_AD_1;
            end

            // upper half
            ST_G_SPL3: begin
                sub_b_next = sub_b_reg
                             + (BLK_BITS'(1) << (c_reg - CLS_W'(MIN_CLASS_BITS)));
                sub_c_next = c_reg;
                ret_next   = ST_G_SPLIT;
                state_next = ST_AD_1;
            end

            ST_G_FIN: begin
                fr_we = 1'b1;
                fr_wd = 1'b0;
                cls_we = 1'b1;
                cls_wd = nc_reg;
                acnt_next[nc_reg] = acnt_reg[nc_reg] + CNT_W'(1);
                usage_next = usage_reg + SIZE_W'(pow2(nc_reg));
                noff_next  = OFF_W'({sub_b_reg, {MIN_CLASS_BITS{1'b0}}});
                if (op_reg == OP_ALLOC) begin
                    ro_next    = OFF_W'({sub_b_reg, {MIN_CLASS_BITS{1'b0}}});
                    us_next    = usable_of(nc_reg);
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_GR_REL;
                end
            end

            // grow: retire the old chunk and merge it back
            ST_GR_REL: begin
                cp_next = usable_of(oc_reg);
                acnt_next[oc_reg] = acnt_reg[oc_reg] - CNT_W'(1);
                usage_next = usage_reg - SIZE_W'(pow2(oc_reg));
                ro_next    = noff_reg;
                us_next    = usable_of(nc_reg);
                woff_next  = WIDE_W'(off_reg);
                c_next     = oc_reg;
                state_next = ST_R_CHK;
            end

            // merge loop: one buddy per pass
            ST_R_CHK: begin
                bud = woff_reg ^ pow2(c_reg);
                if (c_reg >= CLS_W'(MAX_CLASS_BITS)) begin
                    state_next = ST_R_ADD;
                end else if (bud < lo_reg || (bud + pow2(c_reg)) > hi_reg) begin
                    state_next = ST_R_ADD;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = bud[OFF_W-1:MIN_CLASS_BITS];
                    bud_b_next = bud[OFF_W-1:MIN_CLASS_BITS];
                    state_next = ST_R_TST;
                end
            end

            ST_R_TST: begin
                if (rdq_free_reg && rc == c_reg) begin
                    sub_b_next = bud_b_reg;
                    sub_c_next = c_reg;
                    ret_next   = ST_R_UP;
                    state_next = ST_RM_RD;
                end else begin
                    state_next = ST_R_ADD;
                end
            end

            ST_R_UP: begin
                c_next     = c_reg + CLS_W'(1);
                woff_next  = woff_reg & ~(pow2(c_reg + CLS_W'(1)) - WIDE_W'(1));
                state_next = ST_R_CHK;
            end

            ST_R_ADD: begin
                sub_b_next = woff_reg[OFF_W-1:MIN_CLASS_BITS];
                sub_c_next = c_reg;
                ret_next   = ST_DONE;
                state_next = ST_AD_1;
            end

            // shrink: hand back one tail piece per class
            ST_SH: begin
                if (c_reg < oc_reg) begin
                    sub_b_next = off_reg[OFF_W-1:MIN_CLASS_BITS]
                                 + (BLK_BITS'(1) << (c_reg - CLS_W'(MIN_CLASS_BITS)));
                    sub_c_next = c_reg;
                    ret_next   = ST_SH_NX;
                    state_next = ST_AD_1;
                end else begin
                    state_next = ST_SH_FIN;
                end
            end

            ST_SH_NX: begin
                c_next     = c_reg + CLS_W'(1);
                state_next = ST_SH;
            end

            ST_SH_FIN: begin
                cls_we = 1'b1;
                cls_wa = off_reg[OFF_W-1:MIN_CLASS_BITS];
                cls_wd = nc_reg;
                acnt_next[oc_reg] = acnt_reg[oc_reg] - CNT_W'(1);
                acnt_next[nc_reg] = acnt_reg[nc_reg] + CNT_W'(1);
                usage_next = usage_reg - SIZE_W'(pow2(oc_reg) - pow2(nc_reg));
                ro_next    = off_reg;
                us_next    = usable_of(nc_reg);
                state_next = ST_DONE;
            end

            // init: empty lists, then carve maximal aligned chunks
            ST_I_CLR: begin
                for (int i = 0; i < NCLASS; i++) begin
                    head_next[i] = NIL;
                    fcnt_next[i] = '0;
                    acnt_next[i] = '0;
                end
                usage_next = '0;
                woff_next  = lo_reg;
                state_next = ST_I_LOOP;
            end

            ST_I_LOOP: begin
                if (hi_reg >= woff_reg + pow2(CLS_W'(MIN_CLASS_BITS))) begin
                    c_next     = CLS_W'(MIN_CLASS_BITS);
                    state_next = ST_I_TZ;
                end else begin
                    state_next = ST_DONE;
                end
            end

            // alignment of the current offset, one bit a step
            ST_I_TZ: begin
                if (c_reg < CLS_W'(MAX_CLASS_BITS) && !woff_reg[c_reg]) begin
                    c_next = c_reg + CLS_W'(1);
                end else begin
                    state_next = ST_I_FIT;
                end
            end

            ST_I_FIT: begin
                if (c_reg >= CLS_W'(MIN_CLASS_BITS) && hi_reg < woff_reg + pow2(c_reg)) begin
                    c_next = c_reg - CLS_W'(1);
                end else if (c_reg < CLS_W'(MIN_CLASS_BITS)) begin
                    state_next = ST_DONE;
                end else begin
                    sub_b_next = woff_reg[OFF_W-1:MIN_CLASS_BITS];
                    sub_c_next = c_reg;
                    ret_next   = ST_I_NX;
                    state_next = ST_AD_1;
                end
            end

            ST_I_NX: begin
                woff_next  = woff_reg + pow2(c_reg);
                state_next = ST_I_LOOP;
            end

            // unlink sub_b from list sub_c
            ST_RM_RD: begin
                rd_en      = 1'b1;
                rd_addr    = sub_b_reg;
                state_next = ST_RM_WR;
            end

            ST_RM_WR: begin
                if (rdq_prev_reg < NIL) begin
                    nx_we = 1'b1;
                    nx_wa = rdq_prev_reg[BLK_BITS-1:0];
                    nx_wd = rdq_next_reg;
                end else if (head_reg[sub_c_reg] == {1'b0, sub_b_reg}) begin
                    head_next[sub_c_reg] = rdq_next_reg;
                end
                if (rdq_next_reg < NIL) begin
                    pv_we = 1'b1;
                    pv_wa = rdq_next_reg[BLK_BITS-1:0];
                    pv_wd = rdq_prev_reg;
                end
                fcnt_next[sub_c_reg] = fcnt_reg[sub_c_reg] - CNT_W'(1);
                state_next = ret_reg;
            end

            // mark sub_b free in class sub_c and push it on the list
            ST_AD_1: begin
                h = head_reg[sub_c_reg];
                cls_we = 1'b1;
                cls_wd = sub_c_reg;
                fr_we  = 1'b1;
                fr_wd  = 1'b1;
                nx_we  = 1'b1;
                nx_wd  = h;
                pv_we  = 1'b1;
                pv_wd  = NIL;
                head_next[sub_c_reg] = {1'b0, sub_b_reg};
                fcnt_next[sub_c_reg] = fcnt_reg[sub_c_reg] + CNT_W'(1);
                hsave_next = h;
                state_next = (h < NIL) ? ST_AD_2 : ret_reg;
            end

            ST_AD_2: begin
                pv_we = 1'b1;
                pv_wa = hsave_reg[BLK_BITS-1:0];
                pv_wd = {1'b0, sub_b_reg};
                state_next = ret_reg;
            end

            ST_DONE: begin
                if (!mval_reg || m_ready) begin
                    mval_next = 1'b1;
                    mdata_next.status        = st_reg;
                    mdata_next.result_offset = ro_reg;
                    mdata_next.copy_bytes    = cp_reg;
                    mdata_next.usable_bytes  = us_reg;
                    mdata_next.usage_bytes   = usage_next;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NCLASS; i++) begin
                head_reg[i] <= NIL;
                fcnt_reg[i] <= '0;
                acnt_reg[i] <= '0;
            end
            usage_reg <= '0;
            seg_reg   <= SEGMENT_RESET;
            first_reg <= FIRST_RESET;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fcnt_reg  <= fcnt_next;
            acnt_reg  <= acnt_next;
            usage_reg <= usage_next;
            seg_reg   <= seg_next;
            first_reg <= first_next;
            mval_reg  <= mval_next;
        end
    end

    // work and payload registers
    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        op_reg     <= op_next;
        need_v_reg <= need_v_next;
        off_reg    <= off_next;
        woff_reg   <= woff_next;
        c_reg      <= c_next;
        nc_reg     <= nc_next;
        oc_reg     <= oc_next;
        sub_b_reg  <= sub_b_next;
        sub_c_reg  <= sub_c_next;
        hsave_reg  <= hsave_next;
        bud_b_reg  <= bud_b_next;
        noff_reg   <= noff_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        st_reg     <= st_next;
        ro_reg     <= ro_next;
        cp_reg     <= cp_next;
        us_reg     <= us_next;
        mdata_reg  <= mdata_next;
    end

    `BBA_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `BBA_ASSERT_IMP(a_result_from_done, $rose(m_valid), $past(state_reg == ST_DONE), "stray result")
    `BBA_ASSERT_IMP(a_status_code, m_valid, m_data.status == STAT_OK || m_data.status == STAT_NO_MEM || m_data.status == STAT_TOO_BIG, "bad status")
    `BBA_ASSERT_IMP(a_fail_no_chunk, m_valid && m_data.status != STAT_OK, m_data.result_offset == '0 && m_data.usable_bytes == '0 && m_data.copy_bytes == '0, "failed item with chunk")

endmodule
